### rtl/fac_pkg.sv
// ----------------------------------------------------------------------------
// Frustum box culling package
// Shared widths, plane record and queue entry types.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PTR_W       = 3;
  localparam int NORM_W      = 18;
  localparam int COORD_W     = 32;
  localparam int EXT_W       = 31;
  localparam int IDX_W       = 16;
  localparam int QDEPTH      = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic signed [COORD_W-1:0] offset;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [EXT_W-1:0]          ex;
    logic [EXT_W-1:0]          ey;
    logic [EXT_W-1:0]          ez;
    logic [IDX_W-1:0]          index;
    logic                      last;
  } box_t;

endpackage

### rtl/fac_front.sv
// ----------------------------------------------------------------------------
// Frustum cull front end
// Accepts items, loads planes into the store, tags boxes with their index
// and hands boxes to a two-entry queue.
// ----------------------------------------------------------------------------
module fac_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic signed [fac_pkg::NORM_W-1:0]   normal_x,
  input  logic signed [fac_pkg::NORM_W-1:0]   normal_y,
  input  logic signed [fac_pkg::NORM_W-1:0]   normal_z,
  input  logic signed [fac_pkg::COORD_W-1:0]  plane_distance,
  input  logic signed [fac_pkg::COORD_W-1:0]  center_x,
  input  logic signed [fac_pkg::COORD_W-1:0]  center_y,
  input  logic signed [fac_pkg::COORD_W-1:0]  center_z,
  input  logic [fac_pkg::EXT_W-1:0]           extent_x,
  input  logic [fac_pkg::EXT_W-1:0]           extent_y,
  input  logic [fac_pkg::EXT_W-1:0]           extent_z,
  input  logic                                last_box,
  output fac_pkg::plane_t                     planes [fac_pkg::PLANE_COUNT],
  output logic                                q_valid,
  output fac_pkg::box_t                       q_box,
  input  logic                                q_ready
);

  fac_pkg::plane_t          store [fac_pkg::PLANE_COUNT];
  logic [fac_pkg::PTR_W-1:0] wr_ptr;
  logic [fac_pkg::IDX_W-1:0] box_counter;
  fac_pkg::box_t            queue [fac_pkg::QDEPTH];
  logic                     rd_sel;
  logic                     wr_sel;
  logic [1:0]               count;
  logic                     accept;
  logic                     load;
  logic                     push;
  logic                     pop;

  // A plane load waits until no box is left in the queue, so that every box
  // is tested against the planes that were loaded before it.
  assign in_ready = (cmd == fac_pkg::CMD_LOAD) ? (count == 2'd0)
                                               : (count != 2'(fac_pkg::QDEPTH));
  assign accept   = in_valid && in_ready;
  assign load     = accept && (cmd == fac_pkg::CMD_LOAD);
  assign push     = accept && (cmd == fac_pkg::CMD_TEST);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_box    = queue[rd_sel];
  assign planes   = store;

  always_ff @(posedge clk) begin
    if (load) begin
      store[wr_ptr] <= '{nx: normal_x, ny: normal_y, nz: normal_z,
                         offset: plane_distance};
    end
    if (push) begin
      queue[wr_sel] <= '{cx: center_x, cy: center_y, cz: center_z,
                         ex: extent_x, ey: extent_y, ez: extent_z,
                         index: box_counter, last: last_box};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      box_counter <= '0;
      rd_sel      <= 1'b0;
      wr_sel      <= 1'b0;
      count       <= 2'd0;
    end else begin
      if (load) begin
        wr_ptr <= (wr_ptr == fac_pkg::PTR_W'(fac_pkg::PLANE_COUNT - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (push) begin
        // The 16-bit counter wraps naturally at the batch size limit.
        box_counter <= last_box ? '0 : box_counter + 1'b1;
        wr_sel      <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr < fac_pkg::PTR_W'(fac_pkg::PLANE_COUNT)) else $error("plane pointer out of range");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(fac_pkg::QDEPTH)) else $error("queue overfilled");
  a_batch_reset: assert property (@(posedge clk) disable iff (rst)
    push && last_box |=> box_counter == '0) else $error("box index not cleared after batch");
`endif

endmodule

### rtl/fac_back.sv
// ----------------------------------------------------------------------------
// Frustum cull back end
// Three-stage pipeline: products, per-plane sums and compares, AND of tests.
// ----------------------------------------------------------------------------
module fac_back (
  input  logic                         clk,
  input  logic                         rst,
  input  fac_pkg::plane_t              planes [fac_pkg::PLANE_COUNT],
  input  logic                         q_valid,
  input  fac_pkg::box_t                q_box,
  output logic                         q_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         visible,
  output logic [fac_pkg::IDX_W-1:0]    box_index,
  output logic                         batch_end
);

  localparam int PW = 51; // product width, covers 32x18 signed and 31x18 unsigned

  logic                       v1, v2, v3;
  logic                       adv;
  logic [fac_pkg::IDX_W-1:0]  idx1, idx2, idx3;
  logic                       last1, last2, last3;
  logic                       vis3;
  logic signed [PW-1:0]       dx [fac_pkg::PLANE_COUNT];
  logic signed [PW-1:0]       dy [fac_pkg::PLANE_COUNT];
  logic signed [PW-1:0]       dz [fac_pkg::PLANE_COUNT];
  logic signed [PW-1:0]       rx [fac_pkg::PLANE_COUNT];
  logic signed [PW-1:0]       ry [fac_pkg::PLANE_COUNT];
  logic signed [PW-1:0]       rz [fac_pkg::PLANE_COUNT];
  logic signed [PW-1:0]       lim1 [fac_pkg::PLANE_COUNT];
  logic [fac_pkg::PLANE_COUNT-1:0] pass2;
  logic [fac_pkg::PLANE_COUNT-1:0] pass_c;

  // The whole pipeline moves together; it holds when the output stage is full
  // and not being taken.
  assign adv       = !v3 || out_ready;
  assign q_ready   = adv;
  assign out_valid = v3;
  assign visible   = vis3;
  assign box_index = idx3;
  assign batch_end = last3;

  function automatic logic [fac_pkg::NORM_W-1:0] mag(input logic signed [fac_pkg::NORM_W-1:0] n);
    mag = n[fac_pkg::NORM_W-1] ? -n : n;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= q_box.index;
      last1 <= q_box.last;
      for (int i = 0; i < fac_pkg::PLANE_COUNT; i++) begin
        dx[i] <= PW'(q_box.cx * planes[i].nx);
        dy[i] <= PW'(q_box.cy * planes[i].ny);
        dz[i] <= PW'(q_box.cz * planes[i].nz);
        rx[i] <= PW'($signed({1'b0, q_box.ex}) * $signed({1'b0, mag(planes[i].nx)}));
        ry[i] <= PW'($signed({1'b0, q_box.ey}) * $signed({1'b0, mag(planes[i].ny)}));
        rz[i] <= PW'($signed({1'b0, q_box.ez}) * $signed({1'b0, mag(planes[i].nz)}));
        lim1[i] <= -(PW'(planes[i].offset) <<< 16);
      end
      idx2  <= idx1;
      last2 <= last1;
      pass2 <= pass_c;
      idx3  <= idx2;
      last3 <= last2;
      vis3  <= &pass2;
    end
  end

  always_comb begin
    for (int i = 0; i < fac_pkg::PLANE_COUNT; i++) begin
      pass_c[i] = ((PW+3)'(dx[i]) + (PW+3)'(dy[i]) + (PW+3)'(dz[i]) + (PW+3)'(rx[i])
                   + (PW+3)'(ry[i]) + (PW+3)'(rz[i])) >= (PW+3)'(lim1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_ready) else $error("queue drained while stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && v2 |=> v3) else $error("stage lost");
`endif

endmodule

### rtl/frustum_aabb_cull_unit.sv
// ----------------------------------------------------------------------------
// Frustum box culling unit
// Tests boxes (center and extents) against six stored frustum planes.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries two kinds of beats.
// cmd = 0 loads the next plane into a six-entry store; the write pointer
// wraps, so later loads replace the oldest planes. cmd = 1 tests a box and
// yields one beat on the output channel (out_valid/out_ready) with visible,
// box_index and batch_end. Plane loads give no output beat. Load all six
// planes before the first box.
// Throughput is one box beat per cycle while out_ready stays high. A box
// result passes through the queue and then the pipeline stages; the front
// end places boxes in a two-entry queue, and the back end is a three-stage
// pipeline (products, per-plane sum and compare, AND over planes). A plane
// load is held off until the queue is empty. When the receiver stalls the
// pipeline holds, the queue fills, and in_ready drops. Reset clears the
// write pointer, the box counter, the queue and all pipeline valid bits;
// the plane store holds garbage until loaded.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic signed [fac_pkg::NORM_W-1:0]   normal_x,
  input  logic signed [fac_pkg::NORM_W-1:0]   normal_y,
  input  logic signed [fac_pkg::NORM_W-1:0]   normal_z,
  input  logic signed [fac_pkg::COORD_W-1:0]  plane_distance,
  input  logic signed [fac_pkg::COORD_W-1:0]  center_x,
  input  logic signed [fac_pkg::COORD_W-1:0]  center_y,
  input  logic signed [fac_pkg::COORD_W-1:0]  center_z,
  input  logic [fac_pkg::EXT_W-1:0]           extent_x,
  input  logic [fac_pkg::EXT_W-1:0]           extent_y,
  input  logic [fac_pkg::EXT_W-1:0]           extent_z,
  input  logic                                last_box,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                visible,
  output logic [fac_pkg::IDX_W-1:0]           box_index,
  output logic                                batch_end
);

  fac_pkg::plane_t planes [fac_pkg::PLANE_COUNT];
  fac_pkg::box_t   q_box;
  logic            q_valid;
  logic            q_ready;

  fac_front u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd,
    .normal_x, .normal_y, .normal_z, .plane_distance,
    .center_x, .center_y, .center_z,
    .extent_x, .extent_y, .extent_z, .last_box,
    .planes, .q_valid, .q_box, .q_ready
  );

  fac_back u_back (
    .clk, .rst, .planes, .q_valid, .q_box, .q_ready,
    .out_valid, .out_ready, .visible, .box_index, .batch_end
  );

endmodule

### tb/frustum_aabb_cull_unit_tb.sv
// ----------------------------------------------------------------------------
// Frustum box culling unit testbench
// Loads plane sets and streams boxes with random bursts and output stalls;
// every box result is checked against an in-bench culling predictor.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fac_pkg::*;

  localparam int RAND_ITEMS = 440;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic                      op;
    logic signed [NORM_W-1:0]  nx, ny, nz;
    logic signed [COORD_W-1:0] pdist;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [EXT_W-1:0]          ex, ey, ez;
    logic                      last;
    logic                      typed;   // expected result given in the table
    logic                      vis_t;
  } beat_t;

  typedef struct {
    logic             vis;
    logic [IDX_W-1:0] idx;
    logic             last;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready, cmd = CMD_LOAD, last_box = 1'b0;
  logic signed [NORM_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [COORD_W-1:0] plane_distance = '0, center_x = '0, center_y = '0,
    center_z = '0;
  logic [EXT_W-1:0] extent_x = '0, extent_y = '0, extent_z = '0;
  logic out_valid, out_ready = 1'b0, visible, batch_end;
  logic [IDX_W-1:0] box_index;

  frustum_aabb_cull_unit i_dut (.*);

  // Predictor state.
  plane_t         planes[PLANE_COUNT];
  int             wr_slot = 0;
  logic [IDX_W:0] box_count = 0;
  verdict_t       pending_verdicts[$];
  beat_t          table_rows[$];
  int             mismatches = 0;
  int             idle_cycles = 0;
  bit             stim_done = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint iabs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic cull_test(beat_t b);
    longint d, r, lim;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      d = longint'(b.cx) * longint'(planes[i].nx) + longint'(b.cy) * longint'(planes[i].ny)
        + longint'(b.cz) * longint'(planes[i].nz);
      r = longint'({1'b0, b.ex}) * iabs64(longint'(planes[i].nx))
        + longint'({1'b0, b.ey}) * iabs64(longint'(planes[i].ny))
        + longint'({1'b0, b.ez}) * iabs64(longint'(planes[i].nz));
      lim = -(longint'(planes[i].offset) * 65536);
      if (d + r < lim) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_beat(beat_t b);
    verdict_t v;
    if (b.op == CMD_LOAD) begin
      planes[wr_slot] = '{b.nx, b.ny, b.nz, b.pdist};
      wr_slot = (wr_slot + 1 >= PLANE_COUNT) ? 0 : wr_slot + 1;
    end else begin
      v.vis = cull_test(b);
      if (b.typed && v.vis !== b.vis_t) begin
        if (mismatches < 10)
          $display("table row: predictor visible %0b, table %0b", v.vis, b.vis_t);
        mismatches++;
      end
      v.idx = box_count[IDX_W-1:0];
      v.last = b.last;
      pending_verdicts.push_back(v);
      box_count = b.last ? 0 : box_count + 1;
    end
  endtask

  function automatic logic signed [NORM_W-1:0] rand_norm();
    case ($urandom_range(0, 5))
      0: return 18'sh10000;
      1: return -18'sh10000;
      2: return $urandom;          // any code, beyond +-1.0 included
      default: return $signed(NORM_W'($urandom_range(0, 131072))) - 65536;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
    endcase
  endfunction

  function automatic logic [EXT_W-1:0] rand_ext();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom_range(0, 32'h00100000);
    endcase
  endfunction

  function automatic beat_t rand_beat(logic op, int long_batch);
    beat_t b;
    b.op = op;
    b.nx = rand_norm(); b.ny = rand_norm(); b.nz = rand_norm();
    b.pdist = rand_coord();
    b.cx = rand_coord(); b.cy = rand_coord(); b.cz = rand_coord();
    b.ex = rand_ext(); b.ey = rand_ext(); b.ez = rand_ext();
    b.last = long_batch ? 1'b0 : ($urandom_range(0, 15) == 0);
    b.typed = 1'b0; b.vis_t = 1'b0;
    return b;
  endfunction

  function automatic beat_t row(logic op, int nx, int ny, int nz, int pdist,
                                int cx, int cy, int cz, int ex, int ey, int ez,
                                logic last, logic typed, logic vis);
    beat_t b;
    b = '{op, nx, ny, nz, pdist, cx, cy, cz, ex, ey, ez, last, typed, vis};
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    cmd <= b.op;
    normal_x <= b.nx; normal_y <= b.ny; normal_z <= b.nz;
    plane_distance <= b.pdist;
    center_x <= b.cx; center_y <= b.cy; center_z <= b.cz;
    extent_x <= b.ex; extent_y <= b.ey; extent_z <= b.ez;
    last_box <= b.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_beat(b);
  endtask

  // Sender in bursts; valid is lowered only when a gap follows.
  task automatic send_stream(ref beat_t q[$]);
    int burst, gap;
    burst = 0;
    while (q.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_beat(q.pop_front());
      burst--;
    end
  endtask

  // Receiver stall pattern: phases of always-ready, random and heavy stall.
  initial begin
    int phase_left, mode;
    phase_left = 0; mode = 0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        mode = $urandom_range(0, 2);
      end
      phase_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Result check at the edge where the beat is taken.
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10) $display("unexpected result beat idx %0d", box_index);
        mismatches++;
      end else begin
        v = pending_verdicts.pop_front();
        if (visible !== v.vis || box_index !== v.idx || batch_end !== v.last) begin
          if (mismatches < 10)
            $display("mismatch: exp vis %0b idx %0d end %0b, got vis %0b idx %0d end %0b",
                     v.vis, v.idx, v.last, visible, box_index, batch_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
      idle_cycles <= 0;
    else if (!rst)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    beat_t q[$];
    int    wait_cycles;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: six planes with a unit normal and zero offset: x >= 0 half spaces.
    for (int i = 0; i < PLANE_COUNT; i++)
      table_rows.push_back(row(CMD_LOAD, 65536, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    table_rows.push_back(row(CMD_TEST, 0, 0, 0, 0, -65536, 0, 0, 0, 0, 0, 0, 1, 0));
    table_rows.push_back(row(CMD_TEST, 0, 0, 0, 0, -65536, 0, 0, 65536, 0, 0, 0, 1, 1));
    table_rows.push_back(row(CMD_TEST, 0, 0, 0, 0, 32'h80000000, 0, 0, 31'h7fffffff, 0, 0,
                             0, 1, 0));
    table_rows.push_back(row(CMD_TEST, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                             0, 31'h7fffffff, 31'h7fffffff, 1, 1, 1));
    // Extra loads overwrite the oldest planes: most negative normal code, extreme offsets.
    table_rows.push_back(row(CMD_LOAD, -131072, 131071, -65536, 32'h80000000,
                             -1, -1, -1, '1, '1, '1, 1, 0, 0));
    table_rows.push_back(row(CMD_LOAD, 131071, -131072, 65536, 32'h7fffffff,
                             0, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_TEST, -1, -1, -1, -1, 32'h80000000, 32'h80000000,
                             32'h80000000, '1, '1, '1, 0, 0, 0));
    table_rows.push_back(row(CMD_TEST, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 0, 0, 0, 1, 0, 0));
    send_stream(table_rows);

    // Random: plane reloads of varied length and batches of boxes.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 8)) q.push_back(rand_beat(CMD_LOAD, 0));
      q.push_back(rand_beat(CMD_TEST, 0));
    end
    send_stream(q);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending_verdicts.size() > 0 && wait_cycles < 20 * IDLE_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    stim_done = 1;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
